// ----- sv/cicdi_pkg.sv -----
// Shared types and constants for the CIC decimator / interpolator.
// Used by the scaler, the top level, the port checker and the testbench; depends on nothing.
package cicdi_pkg;

	// Register map, one 32-bit register every 4 bytes
	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_RATE   = 2'd1,
		REG_STAGES = 2'd2,
		REG_GAIN   = 2'd3
	} cicdi_reg_t;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Register field widths and reset values
	localparam int RATE_W  = 7;
	localparam int STAGE_W = 4;
	localparam int GAIN_W  = 32;

	localparam logic               MODE_RST   = 1'b0;
	localparam logic [RATE_W-1:0]  RATE_RST   = 7'd1;
	localparam logic [STAGE_W-1:0] STAGE_RST  = 4'd1;
	localparam logic [GAIN_W-1:0]  GAIN_RST   = 32'h8000_0000;

	// Width of the magnitude path in the output scaler
	localparam int SCALE_W = 64;

endpackage

// ----- sv/cicdi_cell.sv -----
// One CIC stage cell: an integrator or a comb with its own state register.
// Hands its result to the next cell each cycle unless the next cell stalls; depends on nothing else.
module cicdi_cell #(
	parameter int W       = 64,
	parameter bit IS_COMB = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         up_valid,
	input  logic [W-1:0] up_data,
	input  logic         up_last,
	output logic         up_ready,
	output logic         dn_valid,
	output logic [W-1:0] dn_data,
	output logic         dn_last,
	input  logic         dn_ready
);

	logic         valid_q;
	logic [W-1:0] data_q;
	logic         last_q;
	logic [W-1:0] state_q;
	logic         take;
	logic [W-1:0] sum;
	logic [W-1:0] diff;

	assign up_ready = !valid_q || dn_ready;
	assign take     = up_valid && up_ready;
	assign sum      = state_q + up_data;
	assign diff     = up_data - state_q;

	// Stage state: running sum or previous input; idle stages keep theirs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take && en) begin
			state_q <= IS_COMB ? up_data : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Item register; a stage past the active count passes the item through
	always_ff @(posedge clk) begin
		if (take) begin
			if (!en) begin
				data_q <= up_data;
			end else begin
				data_q <= IS_COMB ? diff : sum;
			end
			last_q <= up_last;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
	assign dn_last  = last_q;

endmodule

// ----- sv/cicdi_rate.sv -----
// Rate change between the two cell rows: keeps every R-th item when decimating,
// expands each item to R items (value then zeros) when interpolating. No dependencies.
module cicdi_rate #(
	parameter int W  = 64,
	parameter int RW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          interp,
	input  logic [RW-1:0] r_m1,
	input  logic          up_valid,
	input  logic [W-1:0]  up_data,
	output logic          up_ready,
	output logic          dn_valid,
	output logic [W-1:0]  dn_data,
	output logic          dn_last,
	input  logic          dn_ready
);

	logic [W-1:0]  slot_q [2];
	logic [1:0]    cnt_q;
	logic [RW-1:0] k_q;
	logic [RW-1:0] phase_q;
	logic          take;
	logic          keep;
	logic          head_last;
	logic          fire;
	logic          pop;
	logic          push;
	logic          wr_idx;

	// Two-slot buffer: ready depends on fill only, so the rows stay decoupled
	assign up_ready  = (cnt_q != 2'd2);
	assign take      = up_valid && up_ready;
	assign keep      = interp || (phase_q == '0);
	assign head_last = !interp || (k_q == r_m1);
	assign dn_valid  = (cnt_q != 2'd0);
	assign dn_data   = (interp && (k_q != '0)) ? '0 : slot_q[0];
	assign dn_last   = head_last;
	assign fire      = dn_valid && dn_ready;
	assign pop       = fire && head_last;
	assign push      = take && keep;
	assign wr_idx    = (cnt_q == 2'd1) && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			k_q     <= '0;
			phase_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			// position inside the expanded run
			if (fire) begin
				k_q <= head_last ? '0 : k_q + 1'b1;
			end
			// decimation phase; wraps at once if R shrank below it
			if (take && !interp) begin
				phase_q <= (phase_q >= r_m1) ? '0 : phase_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_idx) begin
			slot_q[0] <= up_data;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (push && wr_idx) begin
			slot_q[1] <= up_data;
		end
	end

endmodule

// ----- sv/cicdi_scale.sv -----
// Output scaler: magnitude times Q1.31 gain, round half away from zero, saturate.
// Four pipeline stages; uses cicdi_pkg for the gain and magnitude widths.
module cicdi_scale #(
	parameter int W           = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cicdi_pkg::GAIN_W-1:0] gain,
	input  logic                        up_valid,
	input  logic [W-1:0]                up_data,
	input  logic                        up_last,
	output logic                        up_ready,
	output logic                        dn_valid,
	output logic [SAMPLE_BITS-1:0]      dn_data,
	output logic                        dn_last,
	input  logic                        dn_ready
);

	localparam int SW = cicdi_pkg::SCALE_W;
	localparam logic [SW-1:0] POS_MAX = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [SW-1:0] NEG_MAX = SW'(64'd1 << (SAMPLE_BITS - 1));
	localparam logic [SW-1:0] HI_LIM  = SW'(64'd1 << 40);
	localparam logic [SW-1:0] RND     = SW'(64'd1 << 30);

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic                   adv1, adv2, adv3, adv4;
	logic signed [SW-1:0]   ext;
	logic [SW-1:0]          mag_s1;
	logic                   neg_s1, neg_s2, neg_s3;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic [SW-1:0]          phi_s2, plo_s2;
	logic [SW-1:0]          q_s3;
	logic [SW-1:0]          q_lim;
	logic [SW-1:0]          res;
	logic [SAMPLE_BITS-1:0] out_s4;

	// Each stage moves when it is empty or the next one moves
	assign adv4     = !v_s4 || dn_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign up_ready = adv1;

	assign ext = SW'(signed'(up_data));

	// Saturation of the rounded magnitude, then sign restore
	always_comb begin
		if (neg_s3) begin
			q_lim = (q_s3 > NEG_MAX) ? NEG_MAX : q_s3;
			res   = ~q_lim + 1'b1;
		end else begin
			q_lim = (q_s3 > POS_MAX) ? POS_MAX : q_s3;
			res   = q_lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= up_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// s1: sign and magnitude
		if (adv1) begin
			neg_s1  <= ext[SW-1];
			mag_s1  <= ext[SW-1] ? (~ext + 1'b1) : ext;
			last_s1 <= up_last;
		end
		// s2: two 32x32 partial products
		if (adv2) begin
			phi_s2  <= SW'(mag_s1[SW-1:32]) * SW'(gain);
			plo_s2  <= SW'(mag_s1[31:0]) * SW'(gain);
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
		end
		// s3: combine and round; a huge high part forces saturation
		if (adv3) begin
			q_s3    <= (phi_s2 > HI_LIM) ? NEG_MAX + 1'b1
			                             : (phi_s2 << 1) + ((plo_s2 + RND) >> 31);
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
		end
		// s4: output register
		if (adv4) begin
			out_s4  <= res[SAMPLE_BITS-1:0];
			last_s4 <= last_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_data  = out_s4;
	assign dn_last  = last_s4;

endmodule

// ----- sv/cic_decimator_interpolator_top.sv -----
// CIC decimator / interpolator, top level. An input item passes through both cell rows
// (always traversed in full), the rate stage and the 4-stage scaler before its first result.
// Decimation takes one input per cycle while the output is not stalled; interpolation gives
// one result per cycle while the output is ready, R results per input, set by the rate stage.
// arst_n clears all stage state, the decimation phase and the registers to their defaults.
// Depends on cicdi_pkg, cicdi_cell, cicdi_rate and cicdi_scale.
module cic_decimator_interpolator_top #(
	parameter int MAX_STAGES  = 8,
	parameter int MAX_RATE    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_BITS    = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: sample_in
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: sample_out
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
	output logic                                m_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cicdi_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [cicdi_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [cicdi_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int RW    = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
	localparam int NS    = MAX_STAGES;

	logic                              interp_mode_q;
	logic [cicdi_pkg::RATE_W-1:0]      rate_factor_q;
	logic [cicdi_pkg::STAGE_W-1:0]     stage_count_q;
	logic [cicdi_pkg::GAIN_W-1:0]      output_gain_q;
	logic                              cfg_wr;
	cicdi_pkg::cicdi_reg_t             reg_sel;
	logic [cicdi_pkg::STAGE_W-1:0]     n_eff;
	logic [cicdi_pkg::RATE_W-1:0]      r_m1_full;
	logic [RW-1:0]                     r_m1;
	logic [ACC_BITS-1:0]               x_ext;

	// Cell rows: index 0 is the row input, index NS the row output
	logic                int_v [NS+1];
	logic [ACC_BITS-1:0] int_d [NS+1];
	logic                int_l [NS+1];
	logic                int_r [NS+1];
	logic                cmb_v [NS+1];
	logic [ACC_BITS-1:0] cmb_d [NS+1];
	logic                cmb_l [NS+1];
	logic                cmb_r [NS+1];

	logic                jn_in_v, jn_in_r, jn_v, jn_l, jn_r;
	logic [ACC_BITS-1:0] jn_in_d, jn_d;
	logic                sc_in_v, sc_in_l, sc_in_r;
	logic [ACC_BITS-1:0] sc_in_d;
	logic [SAMPLE_BITS-1:0] sample_out;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = cicdi_pkg::cicdi_reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q <= cicdi_pkg::MODE_RST;
			rate_factor_q <= cicdi_pkg::RATE_RST;
			stage_count_q <= cicdi_pkg::STAGE_RST;
			output_gain_q <= cicdi_pkg::GAIN_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				cicdi_pkg::REG_MODE:   interp_mode_q <= pwdata[0];
				cicdi_pkg::REG_RATE:   rate_factor_q <= pwdata[cicdi_pkg::RATE_W-1:0];
				cicdi_pkg::REG_STAGES: stage_count_q <= pwdata[cicdi_pkg::STAGE_W-1:0];
				cicdi_pkg::REG_GAIN:   output_gain_q <= pwdata[cicdi_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			cicdi_pkg::REG_MODE:   prdata = {{(cicdi_pkg::CFG_DATA_W-1){1'b0}}, interp_mode_q};
			cicdi_pkg::REG_RATE:   prdata = cicdi_pkg::CFG_DATA_W'(rate_factor_q);
			cicdi_pkg::REG_STAGES: prdata = cicdi_pkg::CFG_DATA_W'(stage_count_q);
			cicdi_pkg::REG_GAIN:   prdata = cicdi_pkg::CFG_DATA_W'(output_gain_q);
			default:               prdata = '0;
		endcase
	end

	// Clamp stage count and rate to their usable ranges (zero acts as one)
	always_comb begin
		if (stage_count_q == '0) begin
			n_eff = cicdi_pkg::STAGE_W'(1);
		end else if (stage_count_q > cicdi_pkg::STAGE_W'(MAX_STAGES)) begin
			n_eff = cicdi_pkg::STAGE_W'(MAX_STAGES);
		end else begin
			n_eff = stage_count_q;
		end
		if (rate_factor_q == '0) begin
			r_m1_full = '0;
		end else if (rate_factor_q > cicdi_pkg::RATE_W'(MAX_RATE)) begin
			r_m1_full = cicdi_pkg::RATE_W'(MAX_RATE - 1);
		end else begin
			r_m1_full = rate_factor_q - 1'b1;
		end
	end
	assign r_m1 = r_m1_full[RW-1:0];

	assign x_ext = ACC_BITS'(signed'(s_tdata[SAMPLE_BITS-1:0]));

	// Routing: decimate is in -> integrators -> rate -> combs -> scaler,
	// interpolate is in -> combs -> rate -> integrators -> scaler
	assign int_v[0] = interp_mode_q ? jn_v : s_tvalid;
	assign int_d[0] = interp_mode_q ? jn_d : x_ext;
	assign int_l[0] = interp_mode_q ? jn_l : 1'b0;
	assign cmb_v[0] = interp_mode_q ? s_tvalid : jn_v;
	assign cmb_d[0] = interp_mode_q ? x_ext : jn_d;
	assign cmb_l[0] = interp_mode_q ? 1'b0 : jn_l;
	assign s_tready = interp_mode_q ? cmb_r[0] : int_r[0];

	assign jn_in_v = interp_mode_q ? cmb_v[NS] : int_v[NS];
	assign jn_in_d = interp_mode_q ? cmb_d[NS] : int_d[NS];
	assign jn_r    = interp_mode_q ? int_r[0] : cmb_r[0];

	assign sc_in_v = interp_mode_q ? int_v[NS] : cmb_v[NS];
	assign sc_in_d = interp_mode_q ? int_d[NS] : cmb_d[NS];
	assign sc_in_l = interp_mode_q ? int_l[NS] : cmb_l[NS];

	assign int_r[NS] = interp_mode_q ? sc_in_r : jn_in_r;
	assign cmb_r[NS] = interp_mode_q ? jn_in_r : sc_in_r;

	// Integrator and comb cell rows
	for (genvar i = 0; i < NS; i++) begin : g_cells
		logic en;
		assign en = (cicdi_pkg::STAGE_W'(i) < n_eff);

		cicdi_cell #(.W(ACC_BITS), .IS_COMB(1'b0)) u_int (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (int_v[i]),
			.up_data  (int_d[i]),
			.up_last  (int_l[i]),
			.up_ready (int_r[i]),
			.dn_valid (int_v[i+1]),
			.dn_data  (int_d[i+1]),
			.dn_last  (int_l[i+1]),
			.dn_ready (int_r[i+1])
		);

		cicdi_cell #(.W(ACC_BITS), .IS_COMB(1'b1)) u_cmb (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (cmb_v[i]),
			.up_data  (cmb_d[i]),
			.up_last  (cmb_l[i]),
			.up_ready (cmb_r[i]),
			.dn_valid (cmb_v[i+1]),
			.dn_data  (cmb_d[i+1]),
			.dn_last  (cmb_l[i+1]),
			.dn_ready (cmb_r[i+1])
		);
	end

	cicdi_rate #(.W(ACC_BITS), .RW(RW)) u_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.interp   (interp_mode_q),
		.r_m1     (r_m1),
		.up_valid (jn_in_v),
		.up_data  (jn_in_d),
		.up_ready (jn_in_r),
		.dn_valid (jn_v),
		.dn_data  (jn_d),
		.dn_last  (jn_l),
		.dn_ready (jn_r)
	);

	cicdi_scale #(.W(ACC_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (output_gain_q),
		.up_valid (sc_in_v),
		.up_data  (sc_in_d),
		.up_last  (sc_in_l),
		.up_ready (sc_in_r),
		.dn_valid (m_tvalid),
		.dn_data  (sample_out),
		.dn_last  (m_tlast),
		.dn_ready (m_tready)
	);

	assign m_tdata = OUT_W'(sample_out);

endmodule

// ----- sv/cicdi_checker.sv -----
// Port-level checker for the CIC decimator / interpolator, bound to the top level.
// Depends on cicdi_pkg; sees only the top level's ports.
module cicdi_checker #(
	parameter int OUT_W = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [OUT_W-1:0]                 m_tdata,
	input logic                             m_tlast,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [cicdi_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [cicdi_pkg::CFG_DATA_W-1:0] pwdata,
	input logic [cicdi_pkg::CFG_DATA_W-1:0] prdata,
	input logic                             pready
);

	logic mode_q;
	logic seen_q;

	// Shadow of the mode register and of whether any item went in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cicdi_pkg::MODE_RST;
			seen_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[3:2] == cicdi_pkg::REG_MODE) begin
				mode_q <= pwdata[0];
			end
			if (s_tvalid && s_tready) begin
				seen_q <= 1'b1;
			end
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Every decimation result carries the last flag
	a_dec_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !mode_q |-> m_tlast)
		else $error("decimation result without last flag");

	// No result before any input
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("result before any input item");

	// Mode register reads back what was written
	a_mode_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[3:2] == cicdi_pkg::REG_MODE
		|-> prdata == {{(cicdi_pkg::CFG_DATA_W-1){1'b0}}, mode_q})
		else $error("mode register read mismatch");

endmodule

bind cic_decimator_interpolator_top cicdi_checker #(.OUT_W(OUT_W)) u_cicdi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);

// ----- tb/cic_decimator_interpolator_checker.sv -----
`timescale 1ns / 100ps
// Output checker for the CIC decimator / interpolator: follows register writes and both
// streams, predicts every output item and compares it field by field. Depends on cicdi_pkg.
module cic_decimator_interpolator_checker
	import cicdi_pkg::*;
#(
	parameter int MAX_STAGES  = 8,
	parameter int MAX_RATE    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int DATA_W      = ((SAMPLE_BITS+7)/8)*8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tdata: sample_in
	input  logic [DATA_W-1:0]     s_tdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// tdata: sample_out
	input  logic [DATA_W-1:0]     m_tdata,
	input  logic                  m_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    mismatch_count,
	output int                    pending_results
);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last;
	} filter_out_t;

	localparam logic [96:0] NEG_LIMIT = 97'd1 << (SAMPLE_BITS-1);
	localparam logic [96:0] POS_LIMIT = NEG_LIMIT - 97'd1;

	// Filter state and register copies
	logic [63:0]         integ_sum [MAX_STAGES];
	logic [63:0]         comb_dly [MAX_STAGES];
	int                  dec_phase;
	logic                mode_q;
	logic [RATE_W-1:0]   rate_q;
	logic [STAGE_W-1:0]  stages_q;
	logic [GAIN_W-1:0]   gain_q;
	filter_out_t         awaited_q[$];
	int                  result_no;

	function automatic int active_rate();
		if (rate_q == 0) return 1;
		if (rate_q > MAX_RATE) return MAX_RATE;
		return int'(rate_q);
	endfunction

	function automatic int active_stages();
		if (stages_q == 0) return 1;
		if (stages_q > MAX_STAGES) return MAX_STAGES;
		return int'(stages_q);
	endfunction

	// Integrator chain, wraps at 64 bits
	function automatic logic [63:0] integrate_chain(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) begin
			integ_sum[i] = integ_sum[i] + v;
			v = integ_sum[i];
		end
		return v;
	endfunction

	// Comb chain, differential delay 1
	function automatic logic [63:0] comb_chain(input logic [63:0] v, input int n);
		logic [63:0] d;
		for (int i = 0; i < n; i++) begin
			d = v - comb_dly[i];
			comb_dly[i] = v;
			v = d;
		end
		return v;
	endfunction

	// Exact product with Q1.31 gain, round half away from zero, saturate
	function automatic logic [SAMPLE_BITS-1:0] apply_gain(input logic [63:0] acc);
		logic        neg;
		logic [63:0] mag;
		logic [96:0] prod;
		logic [96:0] q;
		neg  = acc[63];
		mag  = neg ? (~acc + 64'd1) : acc;
		prod = {33'd0, mag} * {65'd0, gain_q};
		q    = (prod + (97'd1 << 30)) >> 31;
		if (neg) begin
			if (q > NEG_LIMIT) q = NEG_LIMIT;
			q = ~q + 97'd1;
		end else if (q > POS_LIMIT) begin
			q = POS_LIMIT;
		end
		return q[SAMPLE_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("ERROR at %0t, output item %0d: %s expected %0h, got %0h",
			$time, result_no, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [63:0] x;
		logic [63:0] v;
		filter_out_t want;
		int          r;
		int          n;
		if (!arst_n) begin
			for (int i = 0; i < MAX_STAGES; i++) begin
				integ_sum[i] = '0;
				comb_dly[i]  = '0;
			end
			dec_phase      = 0;
			mode_q         = MODE_RST;
			rate_q         = RATE_RST;
			stages_q       = STAGE_RST;
			gain_q         = GAIN_RST;
			awaited_q.delete();
			result_no      = 0;
			mismatch_count = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (cicdi_reg_t'(paddr[3:2]))
					REG_MODE:   mode_q   = pwdata[0];
					REG_RATE:   rate_q   = pwdata[RATE_W-1:0];
					REG_STAGES: stages_q = pwdata[STAGE_W-1:0];
					REG_GAIN:   gain_q   = pwdata[GAIN_W-1:0];
					default: ;
				endcase
			end

			// output items against the oldest expectation
			if (m_tvalid && m_tready) begin
				result_no++;
				if (awaited_q.size() == 0) begin
					report_mismatch("item with none expected", 64'd0,
						64'({m_tlast, m_tdata}));
				end else begin
					want = awaited_q.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== want.sample)
						report_mismatch("sample_out", 64'(want.sample),
							64'(m_tdata[SAMPLE_BITS-1:0]));
					if (m_tlast !== want.last)
						report_mismatch("last_of_run", 64'(want.last), 64'(m_tlast));
				end
			end

			// input items: predict what they cause
			if (s_tvalid && s_tready) begin
				x = {{(64-SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}}, s_tdata[SAMPLE_BITS-1:0]};
				r = active_rate();
				n = active_stages();
				if (!mode_q) begin
					v = integrate_chain(x, n);
					if (dec_phase == 0)
						awaited_q.push_back('{apply_gain(comb_chain(v, n)), 1'b1});
					dec_phase++;
					if (dec_phase >= r) dec_phase = 0;
				end else begin
					v = comb_chain(x, n);
					for (int k = 0; k < r; k++) begin
						awaited_q.push_back('{apply_gain(integrate_chain((k == 0) ? v : 64'd0, n)),
							(k == r - 1)});
					end
				end
			end
		end
		pending_results = awaited_q.size();
	end

endmodule

// ----- tb/cic_decimator_interpolator_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the CIC decimator / interpolator: clock, reset, register setup,
// sample stimulus with bursts and output stalls, and the verdict.
// Depends on cicdi_pkg, cic_decimator_interpolator_top and cic_decimator_interpolator_checker.
module cic_decimator_interpolator_top_test;
	import cicdi_pkg::*;

	localparam int MAX_STAGES  = 8;
	localparam int MAX_RATE    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int DATA_W      = ((SAMPLE_BITS+7)/8)*8;
	localparam int LATENCY     = 2*MAX_STAGES + 5;
	localparam int RANDOM_ITEMS = 430;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef enum int {READY_ALWAYS, READY_EVERY_K, READY_COIN, READY_MOSTLY} ready_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [DATA_W-1:0]     s_tdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     m_tdata;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int                    mismatch_count;
	int                    pending_results;
	int                    cycle_count = 0;
	int                    burst_left = 0;
	int                    random_sent = 0;
	logic [15:0]           prev_sample = '0;

	cic_decimator_interpolator_top #(
		.MAX_STAGES(MAX_STAGES), .MAX_RATE(MAX_RATE), .SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(64)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cic_decimator_interpolator_checker #(
		.MAX_STAGES(MAX_STAGES), .MAX_RATE(MAX_RATE), .SAMPLE_BITS(SAMPLE_BITS)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Output side stalls: spans of random length, each with its own ready pattern
	initial begin : receiver
		ready_style_t style;
		int           span;
		int           k;
		m_tready = 1'b0;
		forever begin
			style = ready_style_t'($urandom_range(0, 3));
			span  = $urandom_range(20, 200);
			k     = $urandom_range(2, 4);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (style)
					READY_ALWAYS:  m_tready <= 1'b1;
					READY_EVERY_K: m_tready <= ((i % k) == 0);
					READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
					default:       m_tready <= ((i % 8) < 6);
				endcase
			end
		end
	end

	// Gain that normalizes the DC response: 1/R^N decimating, R/R^N interpolating
	function automatic logic [31:0] unity_gain(input logic mode, input logic [RATE_W-1:0] rate,
			input logic [STAGE_W-1:0] stages);
		int          r;
		int          n;
		logic [63:0] den;
		r   = (rate == 0) ? 1 : ((rate > MAX_RATE) ? MAX_RATE : rate);
		n   = (stages == 0) ? 1 : ((stages > MAX_STAGES) ? MAX_STAGES : stages);
		den = 64'd1;
		for (int i = 0; i < n - int'(mode); i++) den = den * r;
		return 32'((64'h8000_0000 + den / 2) / den);
	endfunction

	// Mix of full-range, small, extreme and repeated (DC) samples
	function automatic logic [15:0] pick_sample(input logic [15:0] last);
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom);
			5, 6: begin
				s = $urandom_range(0, 128);
				s = s - 64;
				return s[15:0];
			end
			7: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return last;
		endcase
	endfunction

	task automatic write_reg(input cicdi_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_settings(input logic mode, input logic [RATE_W-1:0] rate,
			input logic [STAGE_W-1:0] stages, input logic [31:0] gain);
		write_reg(REG_MODE, {31'd0, mode});
		write_reg(REG_RATE, {25'd0, rate});
		write_reg(REG_STAGES, {28'd0, stages});
		write_reg(REG_GAIN, gain);
	endtask

	// One input item, sent in bursts with random gaps
	task automatic send_sample(input logic [15:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 3) == 1 ? $urandom_range(30, 80) : $urandom_range(1, 12);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// Hold the input until every expected item is out, then let the pipe empty
	task automatic settle(input int extra);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic run_phase(input logic mode, input logic [RATE_W-1:0] rate,
			input logic [STAGE_W-1:0] stages, input logic [31:0] gain, input int count,
			input bit hold_mid);
		settle(2 * LATENCY);
		apply_settings(mode, rate, stages, gain);
		for (int i = 0; i < count; i++) begin
			if (hold_mid && i == count / 2) settle(0);
			prev_sample = pick_sample(prev_sample);
			send_sample(prev_sample);
			random_sent++;
		end
	endtask

	initial begin : stimulus
		logic               mode;
		logic [RATE_W-1:0]  rate;
		logic [STAGE_W-1:0] stages;
		logic [31:0]        gain;
		int                 r_eff;
		int                 count;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: pass-through, field extremes
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);

		// zero rate and stages act as one; gain above unity saturates
		settle(2 * LATENCY);
		apply_settings(1'b0, 7'd0, 4'd0, 32'hFFFF_FFFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'd20000);
		send_sample(-16'sd20000);

		// rate and stages above the maximum clamp to it
		settle(2 * LATENCY);
		apply_settings(1'b1, 7'd127, 4'd15, 32'h0000_4000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// leave the decimation phase at 5, then shrink the rate below it
		settle(2 * LATENCY);
		apply_settings(1'b0, 7'd7, 4'd3, unity_gain(1'b0, 7'd7, 4'd3));
		send_sample(16'd1000);
		send_sample(-16'sd3000);
		send_sample(16'd32000);
		send_sample(16'd77);
		send_sample(-16'sd1);
		settle(2 * LATENCY);
		apply_settings(1'b0, 7'd3, 4'd3, unity_gain(1'b0, 7'd3, 4'd3));
		send_sample(16'd500);
		send_sample(16'd500);
		send_sample(-16'sd32768);
		send_sample(16'd12);

		// half gain on odd values: ties round away from zero
		settle(2 * LATENCY);
		apply_settings(1'b0, 7'd1, 4'd1, 32'h4000_0000);
		send_sample(16'd1);
		send_sample(-16'sd1);
		send_sample(16'd3);
		send_sample(-16'sd3);

		// deep stages, full-ratio runs, zero gain; the first one pauses halfway
		run_phase(1'b0, 7'd4, 4'd8, unity_gain(1'b0, 7'd4, 4'd8), 40, 1'b1);
		run_phase(1'b1, 7'd64, 4'd2, unity_gain(1'b1, 7'd64, 4'd2), 3, 1'b0);
		run_phase(1'b0, 7'd64, 4'd3, unity_gain(1'b0, 7'd64, 4'd3), 70, 1'b0);
		run_phase(1'b0, 7'd2, 4'd2, 32'd0, 16, 1'b0);

		// random settings, mostly small ratios
		while (random_sent < RANDOM_ITEMS) begin
			mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: rate = 7'($urandom_range(1, 8));
				7, 8: rate = 7'($urandom_range(9, 64));
				default: rate = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
			endcase
			if ($urandom_range(0, 6) != 0) stages = 4'($urandom_range(1, 8));
			else stages = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: gain = unity_gain(mode, rate, stages);
				7: gain = $urandom;
				8: gain = 32'h8000_0000;
				default: gain = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			endcase
			r_eff = (rate == 0) ? 1 : ((rate > MAX_RATE) ? MAX_RATE : rate);
			count = (mode && r_eff > 16) ? $urandom_range(2, 4) : $urandom_range(8, 40);
			run_phase(mode, rate, stages, gain, count, $urandom_range(0, 3) == 0);
		end

		settle(2 * LATENCY);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
